// ===== hw/rtl/blrf_pkg.sv =====
// shared types and constants for the boundary line row fill block
`default_nettype none
package blrf_pkg;

	localparam int RowW = 6;
	localparam int ColW = 8;
	localparam int SelW = 2;

	localparam logic [SelW-1:0] SEL_RIGHT = 2'd1;
	localparam logic [SelW-1:0] SEL_LEFT  = 2'd2;

	// one row of a run, handed from the sequencer to the column pipeline
	typedef struct packed {
		logic [RowW-1:0] row;
		logic [ColW-1:0] start_col;
		logic [ColW-1:0] offset;
		logic            neg;
		logic            side;
		logic            last;
	} blrf_work_t;

endpackage
`default_nettype wire

// ===== hw/rtl/blrf_seq.sv =====
// run sequencer: request check, slope division and per-row offset stepping
`default_nettype none
module blrf_seq #(
	parameter int ROW_COUNT = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [blrf_pkg::ColW-1:0] start_column,
	input  wire logic [blrf_pkg::RowW-1:0] start_row,
	input  wire logic [blrf_pkg::ColW-1:0] end_column,
	input  wire logic [blrf_pkg::RowW-1:0] end_row,
	input  wire logic [blrf_pkg::SelW-1:0] side_select,
	output logic                           work_valid,
	input  wire logic                      work_ready,
	output blrf_pkg::blrf_work_t           work
);
	import blrf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]      state_q;
	logic [2:0]      cnt_q;
	logic [ColW-1:0] sc_q;
	logic [RowW-1:0] er_q;
	logic [RowW-1:0] row_q;
	logic [RowW-1:0] span_q;
	logic            neg_q;
	logic            side_q;
	logic [ColW-1:0] dvd_q;
	logic [RowW-1:0] drem_q;
	logic [ColW-1:0] acc_q;
	logic [RowW-1:0] arem_q;

	logic            acc_in;
	logic            good;
	logic [RowW-1:0] span_in;
	logic [RowW:0]   trial;
	logic            qbit;
	logic [RowW:0]   rem_sum;
	logic            carry;
	logic            in_range;
	logic            last_row;
	logic            fire;

	assign acc_in   = in_valid && in_ready;
	assign good     = ((side_select == SEL_RIGHT) || (side_select == SEL_LEFT))
		&& (start_row >= end_row);
	assign span_in  = start_row - end_row;
	assign trial    = {drem_q, dvd_q[ColW-1]};
	assign qbit     = trial >= {1'b0, span_q};
	assign rem_sum  = {1'b0, arem_q} + {1'b0, drem_q};
	assign carry    = rem_sum >= {1'b0, span_q};
	assign in_range = {1'b0, row_q} < (RowW+1)'(ROW_COUNT);
	assign last_row = row_q == er_q;
	assign fire     = (state_q == ST_RUN) && (!in_range || work_ready);

	assign in_ready   = state_q == ST_IDLE;
	assign work_valid = (state_q == ST_RUN) && in_range;

	always_comb begin
		work.row       = row_q;
		work.start_col = sc_q;
		work.offset    = acc_q;
		work.neg       = neg_q;
		work.side      = side_q;
		work.last      = last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && good) begin
						state_q <= (span_in == '0) ? ST_RUN : ST_DIV;
						cnt_q   <= '1;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == '0) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (fire && last_row) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sc_q   <= start_column;
			er_q   <= end_row;
			row_q  <= start_row;
			span_q <= span_in;
			neg_q  <= end_column < start_column;
			side_q <= side_select == SEL_LEFT;
			dvd_q  <= (span_in == '0) ? '0
				: (end_column < start_column) ? (start_column - end_column)
				: (end_column - start_column);
			drem_q <= '0;
			acc_q  <= '0;
			arem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q  <= {dvd_q[ColW-2:0], qbit};
			drem_q <= qbit ? RowW'(trial - {1'b0, span_q}) : trial[RowW-1:0];
		end else if (fire) begin
			row_q <= row_q - RowW'(1);
			if (carry) begin
				arem_q <= RowW'(rem_sum - {1'b0, span_q});
				acc_q  <= acc_q + dvd_q + ColW'(1);
			end else begin
				arem_q <= rem_sum[RowW-1:0];
				acc_q  <= acc_q + dvd_q;
			end
		end
	end

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (span_q != '0) |-> (arem_q < span_q))
		else $error("row remainder not below span");

	a_div_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && good && (span_in != '0) |=> (state_q == ST_DIV) && (cnt_q == 3'd7))
		else $error("division did not start");

	a_div_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_RUN))
		else $error("division did not finish in eight steps");

	a_bad_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && !good |=> (state_q == ST_IDLE))
		else $error("rejected request started a run");

	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (acc_q == '0) && (arem_q == '0) |-> (row_q >= er_q))
		else $error("run row below end row");

endmodule
`default_nettype wire

// ===== hw/rtl/boundary_line_row_fill.sv =====
// boundary line row fill: top level with the column pipeline
//
// a request word on the s_axis channel names a start point on the larger row,
// an end point on the smaller row and a side select. for every row below
// ROW_COUNT from the start row down to the end row one word leaves on m_axis
// with the column on the line between the points, truncated toward zero and
// clamped to 0..MAX_COLUMN. tlast marks the end row. requests with a bad side
// select or with the rows reversed are taken and give no words.
// after a request is taken the sequencer does the slope division, one
// quotient bit a cycle in the sequencer divider (none when the rows are equal),
// and then issues one row a cycle while the pipeline does not stall;
// s_axis_tready is high only while the sequencer is idle.
// a row word passes three registers after the sequencer issues it (add, clamp,
// output register). when the receiver stalls the pipeline fills and the
// sequencer waits, nothing is lost or repeated.
// reset empties the pipeline and returns the sequencer to idle.
`default_nettype none
module boundary_line_row_fill #(
	parameter int MAX_COLUMN = 159,
	parameter int ROW_COUNT  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// start_column, start_row, end_column, end_row, zero pad
	input  wire logic [31:0] s_axis_tdata,
	// side_select
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// row_index, boundary_column, zero pad
	output logic [15:0]      m_axis_tdata,
	// boundary_side
	output logic [0:0]       m_axis_tuser,
	output logic             m_axis_tlast
);
	import blrf_pkg::*;

	localparam int ClW = $clog2(MAX_COLUMN + 1);
	localparam int SumW = 11;

	blrf_work_t work;
	logic       work_valid;
	logic       rdy_s1;
	logic       rdy_s2;
	logic       rdy_s3;

	logic                   v_s1;
	logic [RowW-1:0]        row_s1;
	logic                   side_s1;
	logic                   last_s1;
	logic signed [SumW-1:0] col_s1;

	logic            v_s2;
	logic [RowW-1:0] row_s2;
	logic            side_s2;
	logic            last_s2;
	logic [ClW-1:0]  col_s2;

	logic            v_s3;
	logic [RowW-1:0] row_s3;
	logic            side_s3;
	logic            last_s3;
	logic [ColW-1:0] col_s3;

	logic signed [SumW-1:0] sum;
	logic [ClW-1:0]         clamped;
	logic [ClW+ColW-1:0]    col_wide;

	blrf_seq #(
		.ROW_COUNT(ROW_COUNT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.start_column (s_axis_tdata[7:0]),
		.start_row    (s_axis_tdata[13:8]),
		.end_column   (s_axis_tdata[21:14]),
		.end_row      (s_axis_tdata[27:22]),
		.side_select  (s_axis_tuser),
		.work_valid   (work_valid),
		.work_ready   (rdy_s1),
		.work         (work)
	);

	assign rdy_s3 = !v_s3 || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign sum = work.neg
		? $signed({3'b000, work.start_col}) - $signed({3'b000, work.offset})
		: $signed({3'b000, work.start_col}) + $signed({3'b000, work.offset});

	always_comb begin
		priority if (col_s1 <= $signed(SumW'(0))) begin
			clamped = '0;
		end else if (col_s1 >= $signed(SumW'(MAX_COLUMN))) begin
			clamped = ClW'(MAX_COLUMN);
		end else begin
			clamped = ClW'(col_s1);
		end
	end

	assign col_wide = {{ColW{1'b0}}, col_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= work_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			row_s1  <= work.row;
			side_s1 <= work.side;
			last_s1 <= work.last;
			col_s1  <= sum;
		end
		if (rdy_s2) begin
			row_s2  <= row_s1;
			side_s2 <= side_s1;
			last_s2 <= last_s1;
			col_s2  <= clamped;
		end
		if (rdy_s3) begin
			row_s3  <= row_s2;
			side_s3 <= side_s2;
			last_s3 <= last_s2;
			col_s3  <= col_wide[ColW-1:0];
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {2'b00, col_s3, row_s3};
	assign m_axis_tuser  = side_s3;
	assign m_axis_tlast  = last_s3;

endmodule
`default_nettype wire
